FILE: hw/rtl/sfp_pkg.sv
// shared types, constants and the field width table of the snapshot frame parser
package sfp_pkg;

  // frame layout
  localparam int HEADER_BYTES = 24;
  localparam int RECORD_BYTES = 27;
  localparam int MAX_ENTITIES_DEFAULT = 64;

  // field ids
  localparam logic [4:0] FLD_TICK = 5'd0;
  localparam logic [4:0] FLD_COUNT = 5'd4;
  localparam logic [4:0] FLD_FIRST_ENTITY = 5'd5;
  localparam logic [4:0] FLD_LAST = 5'd23;

  // result status codes
  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_COUNT_HIGH = 2'd1;
  localparam logic [1:0] STATUS_BODY_SHORT = 2'd2;
  localparam logic [1:0] STATUS_HDR_SHORT = 2'd3;

  // one accepted input beat
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        frame_start;
    logic [15:0] frame_length;
  } beat_t;

  // one result beat
  typedef struct packed {
    logic [4:0]  field_id;
    logic [5:0]  entity_index;
    logic [63:0] field_value;
    logic [1:0]  status;
    logic        last_of_frame;
  } result_t;

  // bytes in a field, minus one
  function automatic logic [2:0] field_last_byte(input logic [4:0] id);
    logic [2:0] w;
    unique case (id)
      5'd0, 5'd2: w = 3'd7;
      5'd1: w = 3'd3;
      5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd18: w = 3'd1;
      default: w = 3'd0;
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/sfp_ifs.sv
// valid/ready channel interfaces for frame bytes in and parsed fields out

interface sfp_rx_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        frame_start;
  logic [15:0] frame_length;

  modport source (output valid, data_byte, frame_start, frame_length, input ready);
  modport sink (input valid, data_byte, frame_start, frame_length, output ready);
endinterface

interface sfp_tx_if;
  logic        valid;
  logic        ready;
  logic [4:0]  field_id;
  logic [5:0]  entity_index;
  logic [63:0] field_value;
  logic [1:0]  status;
  logic        last_of_frame;

  modport source (output valid, field_id, entity_index, field_value, status, last_of_frame,
                  input ready);
  modport sink (input valid, field_id, entity_index, field_value, status, last_of_frame,
                output ready);
endinterface

FILE: hw/rtl/sfp_in_stage.sv
// input register holding one frame byte beat
module sfp_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sfp_pkg::beat_t in_beat,
  input  logic          advance,
  output logic          beat_valid,
  output sfp_pkg::beat_t beat
);

  logic           held;
  sfp_pkg::beat_t held_beat;

  // take a new beat when empty or when the held one moves on
  assign in_ready = !held || advance;
  assign beat_valid = held && advance;
  assign beat = held_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_beat <= in_beat;
    end
  end

endmodule

FILE: hw/rtl/sfp_parse.sv
// frame state and per-byte field assembly, one byte per cycle
module sfp_parse #(
  parameter int MAX_ENTITIES = sfp_pkg::MAX_ENTITIES_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            beat_valid,
  input  sfp_pkg::beat_t  beat,
  output logic            res_valid,
  output sfp_pkg::result_t res
);

  localparam int CntW = $clog2(MAX_ENTITIES + 1);
  localparam int EntWide = CntW + 6;

  // frame state
  logic            active, active_next;
  logic [2:0]      byte_cnt, byte_cnt_next;
  logic [63:0]     shift, shift_next;
  logic [4:0]      field, field_next;
  logic [CntW-1:0] entity, entity_next;
  logic [CntW-1:0] count, count_next;
  logic [15:0]     body_len, body_len_next;

  // working values with frame start folded in
  logic            act;
  logic [2:0]      cnt;
  logic [63:0]     shf;
  logic [4:0]      fld;
  logic [CntW-1:0] ent;
  logic [63:0]     asm_val;
  logic [15:0]     dcount;
  logic [20:0]     need_bytes;
  logic [CntW:0]   ent_plus;
  logic [EntWide-1:0] ent_wide;

  always_comb begin
    act = beat.frame_start ? 1'b1 : active;
    cnt = beat.frame_start ? 3'd0 : byte_cnt;
    shf = beat.frame_start ? 64'd0 : shift;
    fld = beat.frame_start ? sfp_pkg::FLD_TICK : field;
    ent = beat.frame_start ? '0 : entity;
    asm_val = shf | (64'(beat.data_byte) << {cnt, 3'b000});
    dcount = asm_val[15:0];
    need_bytes = (21'(dcount) << 4) + (21'(dcount) << 3) + (21'(dcount) << 1) + 21'(dcount);
    ent_plus = (CntW + 1)'(ent) + (CntW + 1)'(1);
    ent_wide = EntWide'(ent);

    active_next = active;
    byte_cnt_next = byte_cnt;
    shift_next = shift;
    field_next = field;
    entity_next = entity;
    count_next = count;
    body_len_next = body_len;
    res_valid = 1'b0;
    res.field_id = fld;
    res.entity_index = 6'd0;
    res.field_value = asm_val;
    res.status = sfp_pkg::STATUS_OK;
    res.last_of_frame = 1'b0;

    if (beat_valid) begin
      if (beat.frame_start) begin
        body_len_next = beat.frame_length - 16'(sfp_pkg::HEADER_BYTES);
        active_next = 1'b1;
        byte_cnt_next = 3'd0;
        shift_next = 64'd0;
        field_next = sfp_pkg::FLD_TICK;
        entity_next = '0;
      end
      // frame too short for the header
      if (beat.frame_start && beat.frame_length < 16'(sfp_pkg::HEADER_BYTES)) begin
        active_next = 1'b0;
        res_valid = 1'b1;
        res.field_id = sfp_pkg::FLD_TICK;
        res.field_value = 64'd0;
        res.status = sfp_pkg::STATUS_HDR_SHORT;
        res.last_of_frame = 1'b1;
      end else if (act) begin
        if (cnt != sfp_pkg::field_last_byte(fld)) begin
          byte_cnt_next = cnt + 3'd1;
          shift_next = asm_val;
        end else begin
          byte_cnt_next = 3'd0;
          shift_next = 64'd0;
          res_valid = 1'b1;
          priority if (fld == sfp_pkg::FLD_COUNT) begin
            // entity count checks
            priority if (dcount > 16'(MAX_ENTITIES)) begin
              active_next = 1'b0;
              res.status = sfp_pkg::STATUS_COUNT_HIGH;
              res.last_of_frame = 1'b1;
            end else if (21'(body_len) < need_bytes) begin
              active_next = 1'b0;
              res.status = sfp_pkg::STATUS_BODY_SHORT;
              res.last_of_frame = 1'b1;
            end else if (dcount == 16'd0) begin
              active_next = 1'b0;
              res.last_of_frame = 1'b1;
            end else begin
              count_next = dcount[CntW-1:0];
              field_next = sfp_pkg::FLD_FIRST_ENTITY;
              entity_next = '0;
            end
          end else if (fld < sfp_pkg::FLD_COUNT) begin
            field_next = fld + 5'd1;
          end else if (fld == sfp_pkg::FLD_LAST) begin
            res.entity_index = ent_wide[5:0];
            if (ent_plus >= (CntW + 1)'(count)) begin
              active_next = 1'b0;
              res.last_of_frame = 1'b1;
            end else begin
              entity_next = ent_plus[CntW-1:0];
              field_next = sfp_pkg::FLD_FIRST_ENTITY;
            end
          end else begin
            res.entity_index = ent_wide[5:0];
            field_next = fld + 5'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      byte_cnt <= 3'd0;
      field <= sfp_pkg::FLD_TICK;
      entity <= '0;
      count <= '0;
      body_len <= 16'd0;
      shift <= 64'd0;
    end else begin
      active <= active_next;
      byte_cnt <= byte_cnt_next;
      field <= field_next;
      entity <= entity_next;
      count <= count_next;
      body_len <= body_len_next;
      shift <= shift_next;
    end
  end

endmodule

FILE: hw/rtl/sfp_out_stage.sv
// result register driving the output channel
module sfp_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  sfp_pkg::result_t load_res,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output sfp_pkg::result_t out_res
);

  logic             full;
  sfp_pkg::result_t held;

  // free when empty or being taken this cycle
  assign free = !full || out_ready;
  assign out_valid = full;
  assign out_res = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (out_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= load_res;
    end
  end

endmodule

FILE: hw/rtl/snapshot_frame_parser_core.sv
// Snapshot frame parser: takes one frame byte per cycle on rx and gives each completed
// header or entity field on tx with its id, entity index, value and status. A byte is
// registered in the input register, and the field it completes is loaded into the result
// register when the byte moves on, from where it leaves on tx. With tx ready the block
// sustains one byte every cycle. The only stalls come from backpressure on the single
// result register: while a result waits, no byte moves on. The entity count check
// against MAX_ENTITIES and the body length check happen on the cycle that completes the
// count field.
module snapshot_frame_parser_core #(
  parameter int MAX_ENTITIES = sfp_pkg::MAX_ENTITIES_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  sfp_rx_if.sink    rx,
  sfp_tx_if.source  tx
);

  sfp_pkg::beat_t   in_beat;
  sfp_pkg::beat_t   beat;
  sfp_pkg::result_t res;
  sfp_pkg::result_t out_res;
  logic             beat_valid;
  logic             res_valid;
  logic             free;

  // pack the input beat
  assign in_beat.data_byte = rx.data_byte;
  assign in_beat.frame_start = rx.frame_start;
  assign in_beat.frame_length = rx.frame_length;

  sfp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (rx.valid),
    .in_ready   (rx.ready),
    .in_beat    (in_beat),
    .advance    (free),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  sfp_parse #(
    .MAX_ENTITIES (MAX_ENTITIES)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (beat_valid),
    .beat       (beat),
    .res_valid  (res_valid),
    .res        (res)
  );

  sfp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .load_res  (res),
    .free      (free),
    .out_valid (tx.valid),
    .out_ready (tx.ready),
    .out_res   (out_res)
  );

  // unpack the result beat
  assign tx.field_id = out_res.field_id;
  assign tx.entity_index = out_res.entity_index;
  assign tx.field_value = out_res.field_value;
  assign tx.status = out_res.status;
  assign tx.last_of_frame = out_res.last_of_frame;

endmodule

FILE: hw/rtl/sfp_checker.sv
// port-level checks on the parser output, bound to the top level
module sfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        tx_valid,
  input logic        tx_ready,
  input logic [4:0]  field_id,
  input logic [5:0]  entity_index,
  input logic [63:0] field_value,
  input logic [1:0]  status,
  input logic        last_of_frame
);

  // a stalled result beat holds
  a_tx_hold: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_ready |=> tx_valid && $stable(field_value) && $stable(field_id)
      && $stable(status) && $stable(last_of_frame) && $stable(entity_index))
    else $error("stalled result beat changed");

  // any error ends the frame
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    tx_valid && status != sfp_pkg::STATUS_OK |-> last_of_frame)
    else $error("error result without last_of_frame");

  // short header result is all zero
  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    tx_valid && status == sfp_pkg::STATUS_HDR_SHORT |->
      field_id == 5'd0 && entity_index == 6'd0 && field_value == 64'd0)
    else $error("short frame result not zero");

  // count errors come only with the count field
  a_count_err: assert property (@(posedge clk) disable iff (rst)
    tx_valid && (status == sfp_pkg::STATUS_COUNT_HIGH || status == sfp_pkg::STATUS_BODY_SHORT)
      |-> field_id == sfp_pkg::FLD_COUNT)
    else $error("count error on other field");

  // header fields belong to no entity
  a_hdr_entity: assert property (@(posedge clk) disable iff (rst)
    tx_valid && field_id <= sfp_pkg::FLD_COUNT |-> entity_index == 6'd0)
    else $error("header field with nonzero entity index");

endmodule

bind snapshot_frame_parser_core sfp_checker u_sfp_checker (
  .clk           (clk),
  .rst           (rst),
  .tx_valid      (tx.valid),
  .tx_ready      (tx.ready),
  .field_id      (tx.field_id),
  .entity_index  (tx.entity_index),
  .field_value   (tx.field_value),
  .status        (tx.status),
  .last_of_frame (tx.last_of_frame)
);
